FILE: sv/irs_pkg.sv
`timescale 1ns / 1ps

package irs_pkg;

  // magnitude word and division step counter
  localparam int MAG_W  = 32;
  localparam int STEP_W = $clog2(MAG_W);

  // defaults for the top level parameters
  localparam int MAX_DIGITS_DEF = 32;
  localparam int MAX_BASE_DEF   = 56;

  // field widths
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 6;
  localparam int BASE_W      = 6;
  localparam int SYM_IDX_W   = 6;
  localparam int BASE_CMP_W  = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int NUM_SYM_REG = 7;

  localparam logic [BASE_CMP_W-1:0] MIN_RADIX = BASE_CMP_W'(2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_FIRST = CFG_IDX_W'(1);

  // reset values
  localparam logic [BASE_W-1:0]     BASE_RESET   = BASE_W'(10);
  localparam logic [CFG_DATA_W-1:0] SYM0_RESET   = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYM1_RESET   = 64'h0000000000003938;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // eight symbol bytes per register, symbol 0 in the low byte
  typedef logic [7:0][CHAR_W-1:0] sym_word_t;
  typedef sym_word_t [NUM_SYM_REG-1:0] sym_bank_t;

  // ascii code of a digit value, zero past the last register
  function automatic logic [CHAR_W-1:0] symbol_of(
    input sym_bank_t               bank,
    input logic [SYM_IDX_W-1:0]    digit
  );
    logic [2:0] word_sel;
    logic [2:0] byte_sel;
    word_sel = digit[5:3];
    byte_sel = digit[2:0];
    if (word_sel >= 3'(NUM_SYM_REG)) begin
      return CHAR_NONE;
    end
    return bank[word_sel][byte_sel];
  endfunction

endpackage

FILE: sv/irs_divider.sv
`timescale 1ns / 1ps

module irs_divider #(
  parameter int RADIX_W = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [irs_pkg::MAG_W-1:0] dividend,
  input  logic [RADIX_W-1:0]        divisor,
  output logic                      done,
  output logic [irs_pkg::MAG_W-1:0] quotient,
  output logic [RADIX_W-1:0]        remainder
);

  localparam logic [irs_pkg::STEP_W-1:0] STEP_LAST =
    irs_pkg::STEP_W'(irs_pkg::MAG_W - 1);

  logic                      busy;
  logic [irs_pkg::STEP_W-1:0] step;
  logic [irs_pkg::MAG_W-1:0] quo;
  logic [RADIX_W-1:0]        rem;
  logic [RADIX_W:0]          trial;
  logic [RADIX_W:0]          diff;
  logic                      fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {rem, quo[irs_pkg::MAG_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // sequencing of the 32 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + irs_pkg::STEP_W'(1);
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in from the dividend side
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[irs_pkg::MAG_W-2:0], fits};
      rem <= fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: sv/integer_to_radix_string.sv
`timescale 1ns / 1ps

// signed integer to text in a configurable radix
// input channel: in_valid/in_ready with value, one signed 32-bit beat per string
// output channel: out_valid/out_ready with character, position, last; one beat per
//   character, '-' first for a negative value, then digits most significant first,
//   last high on the final character
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
//   base size, 1 to 7 hold the symbol bytes; always ready, write only while idle
// sequence: digits come from one shared bit-serial divider; each digit needs a start
//   state, 32 shift/subtract steps and a handoff, then each digit character goes
//   through memory read, symbol lookup and output beat, and the sign character
//   through sign load and output beat
// throughput: one value at a time; in_ready is high only when no string is in flight
// a stalled receiver holds the current character in the output register and the
//   sequencer waits
// reset clears the sequencer and output valid, and restores base 10 with the
//   symbols "0123456789"; the digit memory needs no clearing

module integer_to_radix_string #(
  parameter int MAX_DIGITS = irs_pkg::MAX_DIGITS_DEF,
  parameter int MAX_BASE   = irs_pkg::MAX_BASE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [irs_pkg::MAG_W-1:0] value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [irs_pkg::CHAR_W-1:0]     character,
  output logic [irs_pkg::POS_W-1:0]      position,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [irs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int RADIX_W = $clog2(MAX_BASE + 1);
  localparam int DIGIT_W = $clog2(MAX_BASE);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

  localparam logic [irs_pkg::BASE_CMP_W-1:0] MAX_RADIX =
    irs_pkg::BASE_CMP_W'(MAX_BASE);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_WAIT = 7'b0000100,
    S_SIGN = 7'b0001000,
    S_READ = 7'b0010000,
    S_LOAD = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [irs_pkg::BASE_W-1:0] base_size;
  irs_pkg::sym_bank_t         symbols;

  // per-string working registers
  logic [irs_pkg::MAG_W-1:0]  mag;
  logic                       negative;
  logic [RADIX_W-1:0]         radix;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           left;
  logic [ADDR_W-1:0]          rd_idx;
  logic [DIGIT_W-1:0]         rd_data;
  logic [irs_pkg::POS_W-1:0]  pos;

  // digit memory, least significant digit at address 0
  logic [DIGIT_W-1:0]         digit_store [MAX_DIGITS];

  // divider hookup
  logic                       div_start;
  logic                       div_done;
  logic [irs_pkg::MAG_W-1:0]  div_quo;
  logic [RADIX_W-1:0]         div_rem;

  logic [irs_pkg::MAG_W-1:0]     value_u;
  logic [irs_pkg::MAG_W-1:0]     value_mag;
  logic [irs_pkg::BASE_CMP_W-1:0] base_ext;
  logic [irs_pkg::BASE_CMP_W-1:0] radix_clamped;
  logic [CNT_W-1:0]              count_inc;
  logic                          more_digits;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign div_start = (state == S_DIV);

  // magnitude of the incoming value, minimum integer wraps to 2^31
  always_comb begin
    value_u   = value;
    value_mag = value_u[irs_pkg::MAG_W-1] ? (~value_u) + irs_pkg::MAG_W'(1) : value_u;
  end

  // radix clamp to 2 .. MAX_BASE
  always_comb begin
    base_ext = irs_pkg::BASE_CMP_W'(base_size);
    priority if (base_ext < irs_pkg::MIN_RADIX) begin
      radix_clamped = irs_pkg::MIN_RADIX;
    end else if (base_ext > MAX_RADIX) begin
      radix_clamped = MAX_RADIX;
    end else begin
      radix_clamped = base_ext;
    end
  end

  assign count_inc   = count + CNT_W'(1);
  assign more_digits = (div_quo != '0) && (count_inc < CNT_W'(MAX_DIGITS));

  irs_divider #(
    .RADIX_W(RADIX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (radix),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size <= irs_pkg::BASE_RESET;
      symbols   <= {{(irs_pkg::NUM_SYM_REG - 2){irs_pkg::CFG_DATA_W'(0)}},
                    irs_pkg::SYM1_RESET, irs_pkg::SYM0_RESET};
    end else if (cfg_valid) begin
      if (cfg_index == irs_pkg::CFG_BASE_SIZE) begin
        base_size <= cfg_data[irs_pkg::BASE_W-1:0];
      end else begin
        symbols[cfg_index - irs_pkg::CFG_SYM_FIRST] <= cfg_data;
      end
    end
  end

  // digit memory write and registered read
  always_ff @(posedge clk) begin
    if (state == S_WAIT && div_done) begin
      digit_store[count[ADDR_W-1:0]] <= div_rem[DIGIT_W-1:0];
    end
    if (state == S_READ) begin
      rd_data <= digit_store[rd_idx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (more_digits) begin
              state <= S_DIV;
            end else if (negative) begin
              state <= S_SIGN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_SIGN: begin
          out_valid <= 1'b1;
          state     <= S_EMIT;
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= (left != '0) ? S_READ : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mag      <= value_mag;
          negative <= value_u[irs_pkg::MAG_W-1];
          radix    <= RADIX_W'(radix_clamped);
          count    <= '0;
          pos      <= '0;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          mag    <= div_quo;
          count  <= count_inc;
          left   <= count_inc;
          rd_idx <= count[ADDR_W-1:0];
        end
      end
      S_SIGN: begin
        character <= irs_pkg::CHAR_MINUS;
        position  <= pos;
        last      <= 1'b0;
        pos       <= pos + irs_pkg::POS_W'(1);
      end
      S_LOAD: begin
        character <= irs_pkg::symbol_of(symbols, irs_pkg::SYM_IDX_W'(rd_data));
        position  <= pos;
        last      <= (left == CNT_W'(1));
        pos       <= pos + irs_pkg::POS_W'(1);
        left      <= left - CNT_W'(1);
        rd_idx    <= rd_idx - ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/irs_checker.sv
`timescale 1ns / 1ps

module irs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [irs_pkg::CHAR_W-1:0] character,
  input logic [irs_pkg::POS_W-1:0]  position,
  input logic                       last
);

  // a stalled output beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) &&
      $stable(position) && $stable(last))
    else $error("output beat changed while stalled");

  // no new value is taken while a character waits
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while output pending");

  // an accepted value starts conversion, nothing shown at once
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("no conversion after input beat");

  // more characters follow a non-final beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("idle before final character");

  // the final character frees the input side
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("not idle after final character");

endmodule

bind integer_to_radix_string irs_checker u_irs_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .character(character),
  .position (position),
  .last     (last)
);
